[rtl/frls_pkg.sv]
// Package for the fault retry and lockout supervisor.
// Holds widths, the trip-code-to-fault map, register indexes and the shared structs.
// No dependencies.
`default_nettype none

package frls_pkg;

    localparam int CODE_W     = 5;
    localparam int TIMER_BITS = 18;
    localparam int CLEAR_W    = 18;
    localparam int LIMIT_W    = 2;
    localparam int N_CNT      = 8;
    localparam int FAULT_W    = 13;
    localparam int CLS_W      = 4;
    localparam int CMP_W      = (TIMER_BITS > CLEAR_W) ? TIMER_BITS : CLEAR_W;
    localparam int IN_W       = 8;
    localparam int OUT_W      = 24;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CLS_W-1:0]  CLS_NONE   = 4'hF;
    localparam logic [CODE_W-1:0] LINK_CODE  = 5'd17;
    localparam int                HEAT_CNT    = 5;
    localparam int                LOWFLOW_CNT = 7;
    localparam int                ACVOLT_BIT  = 6;
    localparam int                HEAT_BIT    = 10;

    localparam logic [CLEAR_W-1:0] CLEAR_TICKS_RST    = 18'd180000;
    localparam logic [LIMIT_W-1:0] LOCKOUT_LIMIT_RST  = 2'd3;
    localparam logic [LIMIT_W-1:0] LOW_FLOW_LIMIT_RST = 2'd2;

    // Fault bit owned by each retry counter.
    localparam logic [CLS_W-1:0] CNT_BIT [N_CNT] = '{
        4'd1, 4'd2, 4'd5, 4'd7, 4'd8, 4'd10, 4'd11, 4'd12
    };
    // Fault bits that have a retry counter.
    localparam logic [FAULT_W-1:0] COUNTED_MASK = 13'b1_1101_1010_0110;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLEAR_TICKS    = 2'd0,
        CFG_LOCKOUT_LIMIT  = 2'd1,
        CFG_LOW_FLOW_LIMIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CLEAR_W-1:0] clear_ticks;
        logic [LIMIT_W-1:0] lockout_limit;
        logic [LIMIT_W-1:0] low_flow_limit;
    } t_cfg;

    typedef struct packed {
        logic               host_overheat;
        logic               power_on;
        logic               comp_on;
        logic [CODE_W-1:0]  trip_code;
    } t_item;

    typedef struct packed {
        logic               slave_overheat;
        logic               link_error;
        logic [N_CNT-1:0]   locked_mask;
        logic [FAULT_W-1:0] fault_word;
    } t_result;

    // Fault class (bit of the fault word) for each trip code.
    function automatic logic [CLS_W-1:0] code_class(input logic [CODE_W-1:0] code);
        logic [CLS_W-1:0] cls;
        case (code)
            5'd1:    cls = 4'd0;
            5'd2:    cls = 4'd1;
            5'd3:    cls = 4'd1;
            5'd4:    cls = 4'd2;
            5'd5:    cls = 4'd3;
            5'd6:    cls = 4'd4;
            5'd7:    cls = 4'd5;
            5'd8:    cls = 4'd6;
            5'd9:    cls = 4'd7;
            5'd10:   cls = 4'd7;
            5'd11:   cls = 4'd2;
            5'd12:   cls = 4'd2;
            5'd13:   cls = 4'd8;
            5'd14:   cls = 4'd8;
            5'd15:   cls = 4'd8;
            5'd16:   cls = 4'd8;
            5'd18:   cls = 4'd9;
            5'd19:   cls = 4'd10;
            5'd20:   cls = 4'd11;
            5'd22:   cls = 4'd2;
            5'd23:   cls = 4'd12;
            default: cls = CLS_NONE;
        endcase
        return cls;
    endfunction

endpackage

`default_nettype wire

[rtl/frls_cfg.sv]
// Configuration register file of the fault retry and lockout supervisor.
// Depends on frls_pkg.
`default_nettype none

module frls_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_wr_en,
    input  wire logic [frls_pkg::CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [frls_pkg::CLEAR_W-1:0]   i_wr_data,
    output frls_pkg::t_cfg                      o_cfg
);
    import frls_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            case (t_cfg_idx'(i_wr_index))
                CFG_CLEAR_TICKS:    n_cfg.clear_ticks    = i_wr_data;
                CFG_LOCKOUT_LIMIT:  n_cfg.lockout_limit  = i_wr_data[LIMIT_W-1:0];
                CFG_LOW_FLOW_LIMIT: n_cfg.low_flow_limit = i_wr_data[LIMIT_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clear_ticks    <= CLEAR_TICKS_RST;
            r_cfg.lockout_limit  <= LOCKOUT_LIMIT_RST;
            r_cfg.low_flow_limit <= LOW_FLOW_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

[rtl/frls_state.sv]
// Fault state of the supervisor: flag word, retry counters, forgetting timers
// and the one-tick update applied to each word. Depends on frls_pkg.
`default_nettype none

module frls_state (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_en,
    input  frls_pkg::t_item i_item,
    input  frls_pkg::t_cfg  i_cfg,
    output frls_pkg::t_result o_res
);
    import frls_pkg::*;

    logic [FAULT_W-1:0]    r_fault;
    logic [LIMIT_W-1:0]    r_cnt [N_CNT];
    logic [TIMER_BITS-1:0] r_tmr [N_CNT];
    logic [CODE_W-1:0]     r_prev;
    logic                  r_link;
    logic                  r_hot;

    logic [FAULT_W-1:0]    n_fault;
    logic [LIMIT_W-1:0]    n_cnt [N_CNT];
    logic [TIMER_BITS-1:0] n_tmr [N_CNT];
    logic                  n_link;
    logic                  n_hot;
    logic [N_CNT-1:0]      w_locked;

    always_comb begin
        logic [CLS_W-1:0]      cls;
        logic [LIMIT_W-1:0]    lim;
        logic [LIMIT_W-1:0]    cnt;
        logic [TIMER_BITS-1:0] tmr;
        logic [TIMER_BITS-1:0] tmr_inc;
        logic                  trip_edge;

        cls       = code_class(i_item.trip_code);
        trip_edge = (i_item.trip_code != '0) && (r_prev == '0);
        n_fault   = r_fault;
        n_link    = r_link;
        n_hot     = r_hot;
        w_locked  = '0;

        // Timers, power off and compressor-off clears, one counter each.
        for (int c = 0; c < N_CNT; c++) begin
            lim = (c == LOWFLOW_CNT) ? i_cfg.low_flow_limit : i_cfg.lockout_limit;
            cnt = r_cnt[c];
            tmr = r_tmr[c];
            tmr_inc = (tmr != '1) ? tmr + 1'b1 : tmr;
            if (cnt != '0 && cnt < lim) begin
                if (CMP_W'(tmr_inc) > CMP_W'(i_cfg.clear_ticks)) begin
                    tmr = '0;
                    cnt = '0;
                end else begin
                    tmr = tmr_inc;
                end
            end else begin
                tmr = '0;
            end
            if (!i_item.power_on)
                cnt = '0;
            if (!i_item.comp_on && cls != CNT_BIT[c] && cnt < lim) begin
                // The heatsink counter clears the slave flag; bit 10 follows below.
                if (c == HEAT_CNT)
                    n_hot = 1'b0;
                else
                    n_fault[CNT_BIT[c]] = 1'b0;
            end
            n_cnt[c] = cnt;
            n_tmr[c] = tmr;
        end

        if (!i_item.comp_on) begin
            if (cls != CLS_W'(ACVOLT_BIT))
                n_fault[ACVOLT_BIT] = 1'b0;
            if (i_item.trip_code != LINK_CODE)
                n_link = 1'b0;
        end

        if (trip_edge) begin
            if (i_item.trip_code == LINK_CODE) begin
                n_link = 1'b1;
            end else begin
                // A counted fault only counts when its bit was clear.
                for (int c = 0; c < N_CNT; c++) begin
                    lim = (c == LOWFLOW_CNT) ? i_cfg.low_flow_limit : i_cfg.lockout_limit;
                    if (cls == CNT_BIT[c] && !n_fault[CNT_BIT[c]]) begin
                        if (c == HEAT_CNT)
                            n_hot = 1'b1;
                        else
                            n_fault[CNT_BIT[c]] = 1'b1;
                        if (n_cnt[c] < lim)
                            n_cnt[c] = n_cnt[c] + 1'b1;
                    end
                end
                for (int b = 0; b < FAULT_W; b++) begin
                    if (!COUNTED_MASK[b] && cls == CLS_W'(b))
                        n_fault[b] = 1'b1;
                end
            end
        end

        n_fault[HEAT_BIT] = n_hot | i_item.host_overheat;

        for (int c = 0; c < N_CNT; c++) begin
            lim = (c == LOWFLOW_CNT) ? i_cfg.low_flow_limit : i_cfg.lockout_limit;
            w_locked[c] = (n_cnt[c] >= lim);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= '0;
            r_prev  <= '0;
            r_link  <= 1'b0;
            r_hot   <= 1'b0;
            for (int c = 0; c < N_CNT; c++) begin
                r_cnt[c] <= '0;
                r_tmr[c] <= '0;
            end
        end else if (i_en) begin
            r_fault <= n_fault;
            r_prev  <= i_item.trip_code;
            r_link  <= n_link;
            r_hot   <= n_hot;
            for (int c = 0; c < N_CNT; c++) begin
                r_cnt[c] <= n_cnt[c];
                r_tmr[c] <= n_tmr[c];
            end
        end
    end

    assign o_res.fault_word     = n_fault;
    assign o_res.locked_mask    = w_locked;
    assign o_res.link_error     = n_link;
    assign o_res.slave_overheat = n_hot;

endmodule

`default_nettype wire

[rtl/fault_retry_lockout_supervisor.sv]
// Channel   Dir  Handshake                         Payload
// s_axis    in   i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata  (8 bits, one tick)
// m_axis    out  o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata  (24 bits, one result)
// cfg       in   i_cfg_valid / o_cfg_ready          i_cfg_index, i_cfg_data
//
// One word is accepted per cycle while the output is not stalled; its result is loaded
// into the output register from the state update that reads the input register.
// The state update is one combinational pass over all eight counters per word.
// Synchronous active-low reset clears all fault state and loads the register defaults.
// A stalled output holds the output register and the fault state; the input register
// takes one more word and then holds it.
// Top level; depends on frls_pkg, frls_cfg and frls_state.
`default_nettype none

module fault_retry_lockout_supervisor (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [4:0] trip_code, [5] comp_on, [6] power_on, [7] host_overheat
    input  wire logic [frls_pkg::IN_W-1:0]      i_s_axis_tdata,
    output logic                                o_m_axis_tvalid,
    input  wire logic                           i_m_axis_tready,
    // [12:0] fault_word, [20:13] locked_mask, [21] link_error,
    // [22] slave_overheat, [23] zero
    output logic [frls_pkg::OUT_W-1:0]          o_m_axis_tdata,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [frls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [frls_pkg::CLEAR_W-1:0]   i_cfg_data
);
    import frls_pkg::*;

    logic              r_s1_valid;
    t_item             r_s1_item;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    logic              w_adv;
    t_cfg              w_cfg;
    t_result           w_res;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_s1_valid || w_adv;
    assign o_cfg_ready     = 1'b1;

    frls_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    frls_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_s1_valid && w_adv),
        .i_item  (r_s1_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_axis_tready)
                r_s1_valid <= i_s_axis_tvalid;
            if (w_adv)
                r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid)
            r_s1_item <= t_item'(i_s_axis_tdata);
        if (w_adv && r_s1_valid)
            r_out_data <= {1'b0, w_res};
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

`ifndef SYNTHESIS
    // A word in the input register that moves on always lands in the output register.
    a_stage_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && w_adv |=> o_m_axis_tvalid)
        else $error("input word lost between pipeline stages");

    // Input is refused only when both stages are full and the output is stalled.
    a_ready_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> r_s1_valid && r_out_valid && !i_m_axis_tready)
        else $error("input refused without a full stalled pipeline");

    // The heatsink fault bit is always set when the slave overheat flag is set.
    a_heat_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[22] |-> o_m_axis_tdata[HEAT_BIT])
        else $error("slave overheat without heatsink fault bit");
`endif

endmodule

`default_nettype wire
